FILE: sv/nps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nps_pkg;

	// Palette geometry
	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W         = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);

	// Field widths
	localparam int INDEX_W = 8;
	localparam int COLOR_W = 16;
	localparam int DIST_W  = 10;
	localparam int PC_W    = 8;
	localparam int EXT_W   = 9;

	// Request queue between front and back (depth a power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [INDEX_W-1:0] index;
		logic [COLOR_W-1:0] color;
	} q_item_t;

	typedef enum logic [0:0] {
		BK_IDLE,
		BK_SCAN
	} bk_state_t;

	// Manhattan distance on 1555 colors, bit 15 ignored, channels scaled by 8
	function automatic logic [DIST_W-1:0] color_dist(input logic [COLOR_W-1:0] a,
		input logic [COLOR_W-1:0] b);
		logic [4:0] dr;
		logic [4:0] dg;
		logic [4:0] db;
		logic [6:0] sum;
		dr  = (a[14:10] > b[14:10]) ? (a[14:10] - b[14:10]) : (b[14:10] - a[14:10]);
		dg  = (a[9:5] > b[9:5]) ? (a[9:5] - b[9:5]) : (b[9:5] - a[9:5]);
		db  = (a[4:0] > b[4:0]) ? (a[4:0] - b[4:0]) : (b[4:0] - a[4:0]);
		sum = 7'(dr) + 7'(dg) + 7'(db);
		return {sum, 3'b000};
	endfunction

endpackage

`default_nettype wire

FILE: sv/nps_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: palette write or nearest-color query
interface nps_req_if;
	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic [nps_pkg::INDEX_W-1:0]    entry_index;
	logic [nps_pkg::COLOR_W-1:0]    color_word;

	modport source (output valid, output req_type, output entry_index, output color_word,
		input ready);
	modport sink (input valid, input req_type, input entry_index, input color_word,
		output ready);
endinterface

// Result channel: one transfer per query
interface nps_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [nps_pkg::INDEX_W-1:0]    best_index;
	logic [nps_pkg::DIST_W-1:0]     best_distance;
	logic                           palette_empty;

	modport source (output valid, output best_index, output best_distance,
		output palette_empty, input ready);
	modport sink (input valid, input best_index, input best_distance,
		input palette_empty, output ready);
endinterface

`default_nettype wire

FILE: sv/nps_front.sv
`timescale 1ns / 1ps
`default_nettype none

module nps_front (
	input  wire                  clk,
	input  wire                  arst_n,
	nps_req_if.sink              req,
	output logic                 q_valid,
	input  wire                  q_ready,
	output nps_pkg::q_item_t     q_item
);

	nps_pkg::q_item_t                 fifo_q [nps_pkg::QUEUE_DEPTH];
	logic [nps_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [nps_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [nps_pkg::QCNT_W-1:0]       cnt_q;
	nps_pkg::q_item_t                 in_item;
	logic                             push;
	logic                             pop;

	// Classify the incoming transfer
	always_comb begin
		in_item.op    = req.req_type ? nps_pkg::OP_QUERY : nps_pkg::OP_WRITE;
		in_item.index = req.entry_index;
		in_item.color = req.color_word;
	end

	assign req.ready = (cnt_q != nps_pkg::QCNT_W'(nps_pkg::QUEUE_DEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign pop       = q_valid && q_ready;
	assign q_item    = fifo_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill level (depth is a power of two, pointers wrap)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/nps_back.sv
`timescale 1ns / 1ps
`default_nettype none

module nps_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [nps_pkg::PC_W-1:0]      cfg_wdata,
	input  wire                          q_valid,
	output logic                         q_ready,
	input  wire nps_pkg::q_item_t        q_item,
	nps_rsp_if.source                    rsp
);

	localparam int IW = nps_pkg::IDX_W;
	localparam int CW = nps_pkg::CNT_W;

	nps_pkg::bk_state_t                 state_q;
	nps_pkg::bk_state_t                 state_d;

	logic [nps_pkg::PC_W-1:0]           pc_q;
	logic [nps_pkg::COLOR_W-1:0]        mem [nps_pkg::PALETTE_DEPTH];
	logic [nps_pkg::PALETTE_DEPTH-1:0]  vld_q;

	logic [nps_pkg::COLOR_W-1:0]        qcolor_q;
	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      issued_q;

	logic                               live_s1;
	logic [IW-1:0]                      idx_s1;
	logic [nps_pkg::COLOR_W-1:0]        data_s1;
	logic                               ent_vld_s1;
	logic                               live_s2;
	logic [IW-1:0]                      idx_s2;
	logic [nps_pkg::DIST_W-1:0]         dist_s2;

	logic                               found_q;
	logic [IW-1:0]                      best_idx_q;
	logic [nps_pkg::DIST_W-1:0]         best_dist_q;

	logic                               rsp_valid_q;
	logic [nps_pkg::INDEX_W-1:0]        rsp_idx_q;
	logic [nps_pkg::DIST_W-1:0]         rsp_dist_q;
	logic                               rsp_empty_q;

	logic [nps_pkg::EXT_W-1:0]          pc_ext;
	logic [nps_pkg::EXT_W-1:0]          pc_clamp;
	logic                               in_range;
	logic                               mem_we;
	logic                               start_scan;
	logic                               finish;
	logic                               issue;
	logic                               scan_done;
	logic                               out_free;
	logic [IW-1:0]                      rd_addr;
	logic [nps_pkg::COLOR_W-1:0]        entry_s1;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (cfg_we) begin
			pc_q <= cfg_wdata;
		end
	end

	// Searched count limited to the palette depth
	assign pc_ext   = {1'b0, pc_q};
	assign pc_clamp = (pc_ext > nps_pkg::EXT_W'(nps_pkg::PALETTE_DEPTH)) ?
		nps_pkg::EXT_W'(nps_pkg::PALETTE_DEPTH) : pc_ext;
	assign in_range = ({1'b0, q_item.index} < nps_pkg::EXT_W'(nps_pkg::PALETTE_DEPTH));

	assign issue     = (state_q == nps_pkg::BK_SCAN) && (issued_q != count_q);
	assign scan_done = (issued_q == count_q) && !live_s1 && !live_s2;
	assign out_free  = !rsp_valid_q || rsp.ready;
	assign rd_addr   = issued_q[IW-1:0];

	// Sequencer: next state and control
	always_comb begin
		state_d    = state_q;
		q_ready    = 1'b0;
		mem_we     = 1'b0;
		start_scan = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			nps_pkg::BK_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					if (q_item.op == nps_pkg::OP_WRITE) begin
						mem_we = in_range;
					end else begin
						start_scan = 1'b1;
						state_d    = nps_pkg::BK_SCAN;
					end
				end
			end
			nps_pkg::BK_SCAN: begin
				if (scan_done && out_free) begin
					finish  = 1'b1;
					state_d = nps_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = nps_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nps_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Palette memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_item.index[IW-1:0]] <= q_item.color;
		end
		data_s1 <= mem[rd_addr];
	end

	// Written-entry flags; an unwritten entry reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[q_item.index[IW-1:0]] <= 1'b1;
		end
	end

	// Query setup and scan pipeline payload
	always_ff @(posedge clk) begin
		if (start_scan) begin
			qcolor_q <= q_item.color;
			count_q  <= CW'(pc_clamp);
		end
		ent_vld_s1 <= vld_q[rd_addr];
		idx_s1     <= rd_addr;
		idx_s2     <= idx_s1;
		dist_s2    <= nps_pkg::color_dist(qcolor_q, entry_s1);
	end

	assign entry_s1 = ent_vld_s1 ? data_s1 : '0;

	// Scan counter and pipeline occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q <= '0;
			live_s1  <= 1'b0;
			live_s2  <= 1'b0;
		end else begin
			if (start_scan) begin
				issued_q <= '0;
			end else if (issue) begin
				issued_q <= issued_q + 1'b1;
			end
			live_s1 <= issue;
			live_s2 <= live_s1;
		end
	end

	// Running best; strict less-than keeps the lowest index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (start_scan) begin
			found_q <= 1'b0;
		end else if (live_s2) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (live_s2 && (!found_q || (dist_s2 < best_dist_q))) begin
			best_idx_q  <= idx_s2;
			best_dist_q <= dist_s2;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_idx_q   <= found_q ? nps_pkg::INDEX_W'(best_idx_q) : '0;
			rsp_dist_q  <= found_q ? best_dist_q : '0;
			rsp_empty_q <= !found_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.best_index    = rsp_idx_q;
	assign rsp.best_distance = rsp_dist_q;
	assign rsp.palette_empty = rsp_empty_q;

endmodule

`default_nettype wire

FILE: sv/nearest_palette_color_search_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                   Transfer
// req       in   req_type, entry_index, color_word         valid && ready
// rsp       out  best_index, best_distance, palette_empty  valid && ready
// cfg       in   cfg_wdata (palette_count)                 cfg_we
//
// A write leaves the queue without a scan; a query holds the back end while
// it reads one palette entry per cycle from the palette memory, and while the
// result register waits on rsp.
// Reset clears the count register and all palette entries (per-entry flags).
// A two-entry queue lets requests arrive while a query scans; the result
// register holds a finished query until rsp takes it.

module nearest_palette_color_search_top (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_we,
	input  wire [nps_pkg::PC_W-1:0]  cfg_wdata,
	nps_req_if.sink                  req,
	nps_rsp_if.source                rsp
);

	logic              q_valid;
	logic              q_ready;
	nps_pkg::q_item_t  q_item;

	nps_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item)
	);

	nps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
